// ===== rtl/core/irkp_pkg.sv =====
// ----------------------------------------------------------------------------
// irkp_pkg: shared types and constants for the IR key pairing engine
// Holds the item and result payload types, the item kinds, the pairing
// states, the packet codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package irkp_pkg;

  // Default sizes of the key and the acknowledge train.
  localparam int KEY_CHUNKS_DEF  = 8;
  localparam int ACK_REPEATS_DEF = 3;

  // Widest chunk select that the supported key sizes (up to 16 chunks) need.
  localparam int CHUNK_SEL_W = 4;

  // Fixed packet codes.
  localparam logic [15:0] START_ADDR = 16'hABCD;
  localparam logic [7:0]  START_CMD  = 8'hF0;
  localparam logic [15:0] ACK_ADDR   = 16'hDCBA;
  localparam logic [7:0]  ACK_CMD    = 8'hF1;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_RESEND_INTERVAL = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES     = 4'd1;
  localparam logic [15:0] RESEND_RESET  = 16'd1200;
  localparam logic [3:0]  RETRIES_RESET = 4'd10;

  // Item kinds.
  typedef enum logic [2:0] {
    KIND_ENTER  = 3'd0,
    KIND_START  = 3'd1,
    KIND_PACKET = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_LOAD   = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  // Reported pairing states.
  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_WAIT_ACK  = 3'd3,
    ST_RECEIVING = 3'd4,
    ST_SUCCESS   = 3'd5,
    ST_FAILED    = 3'd6
  } pair_state_t;

  // Packets that one item asks to have sent.
  typedef enum logic [1:0] {
    PLAN_NONE  = 2'd0,
    PLAN_BURST = 2'd1,
    PLAN_ACK   = 2'd2
  } plan_t;

  // Content of one result.
  typedef enum logic [1:0] {
    PKT_NONE  = 2'd0,
    PKT_START = 2'd1,
    PKT_CHUNK = 2'd2,
    PKT_ACK   = 2'd3
  } pkt_t;

  // Input item payload.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] ir_address;
    logic [7:0]  ir_command;
    logic [2:0]  chunk_index;
    logic [15:0] chunk_value;
  } item_t;

  // Result payload.
  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_address;
    logic [7:0]  send_command;
    logic [2:0]  pair_status;
    logic        key_ready;
    logic [15:0] key_word;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   capture;
    logic                   execute;
    logic                   emit;
    pkt_t                   pkt;
    logic [CHUNK_SEL_W-1:0] chunk;
    logic                   last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    plan_t plan;
    logic  out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/irkp_ctrl.sv =====
// ----------------------------------------------------------------------------
// irkp_ctrl: sequencing controller
// Accepts one item, has the datapath execute it, then steps through the
// results it causes (one without a packet, a key burst or an acknowledge
// train), one result per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module irkp_ctrl
  import irkp_pkg::*;
#(
  parameter int KEY_CHUNKS  = KEY_CHUNKS_DEF,
  parameter int ACK_REPEATS = ACK_REPEATS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  output ctl_cmd_t      cmd,
  input  wire ctl_sts_t sts
);

  localparam int STEP_W = $clog2(KEY_CHUNKS + ACK_REPEATS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state, state_next;
  plan_t             plan;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_dec;
  logic              emit_last;
  pkt_t              emit_pkt;

  // Items are taken only between items.
  assign item_stall = (state != S_IDLE);

  // Decode the current step into the result to produce.
  assign step_dec = step - STEP_W'(1);

  always_comb begin
    emit_pkt  = PKT_NONE;
    emit_last = 1'b1;
    case (plan)
      PLAN_BURST: begin
        emit_pkt  = (step == '0) ? PKT_START : PKT_CHUNK;
        emit_last = (step == STEP_W'(KEY_CHUNKS));
      end
      PLAN_ACK: begin
        emit_pkt  = PKT_ACK;
        emit_last = (step == STEP_W'(ACK_REPEATS - 1));
      end
      default: begin
        emit_pkt  = PKT_NONE;
        emit_last = 1'b1;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.capture = (state == S_IDLE) && item_valid;
    cmd.execute = (state == S_EXEC);
    cmd.emit    = (state == S_EMIT) && sts.out_free;
    cmd.pkt     = emit_pkt;
    cmd.chunk   = CHUNK_SEL_W'(step_dec);
    cmd.last    = emit_last;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free && emit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, plan and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      plan  <= PLAN_NONE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        plan <= sts.plan;
        step <= '0;
      end else if (cmd.emit) begin
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/irkp_datapath.sv =====
// ----------------------------------------------------------------------------
// irkp_datapath: pairing state, key stores and result register
// Holds the configuration registers, the protocol state, both key stores,
// the chunk bitmap and the output register. Executes one captured item on
// command and builds each result as the controller steps through them.
// ----------------------------------------------------------------------------
`default_nettype none

module irkp_datapath
  import irkp_pkg::*;
#(
  parameter int KEY_CHUNKS  = KEY_CHUNKS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire item_t                  item,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]            cfg_data,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_t                     result,
  input  wire ctl_cmd_t               cmd,
  output ctl_sts_t                    sts
);

  localparam int IDX_W = (KEY_CHUNKS > 1) ? $clog2(KEY_CHUNKS) : 1;

  // Configuration.
  logic [15:0] resend_interval;
  logic [3:0]  max_retries;

  // Captured item and protocol state.
  item_t               item_r;
  logic [2:0]          protocol_state;
  logic                is_initiator;
  logic [3:0]          retry_count;
  logic [15:0]         elapsed_ms;
  logic [KEY_CHUNKS-1:0] chunk_seen_map;
  logic                key_valid;
  logic [15:0]         key_word;
  logic [15:0]         local_key [KEY_CHUNKS];
  logic [15:0]         rx_key    [KEY_CHUNKS];

  // Next values from the execute step.
  logic [2:0]            protocol_state_next;
  logic                  is_initiator_next;
  logic [3:0]            retry_count_next;
  logic [15:0]           elapsed_ms_next;
  logic [KEY_CHUNKS-1:0] chunk_seen_map_next;
  logic                  key_valid_next;
  plan_t                 plan;
  logic                  load_we;
  logic                  rx_we;
  logic                  copy_en;

  logic                  idx_ok;
  logic                  cmd_ok;
  logic [IDX_W-1:0]      ld_idx;
  logic [IDX_W-1:0]      rx_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [15:0]           rd_data;
  logic                  is_start_pkt;
  logic                  is_ack_pkt;
  logic [15:0]           elapsed_inc;
  logic [KEY_CHUNKS-1:0] map_set;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      resend_interval <= RESEND_RESET;
      max_retries     <= RETRIES_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RESEND_INTERVAL) resend_interval <= cfg_data;
      if (cfg_index == REG_MAX_RETRIES)     max_retries     <= cfg_data[3:0];
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= item;
  end

  // Field decode of the captured item.
  assign idx_ok       = (5'(item_r.chunk_index) < 5'(KEY_CHUNKS));
  assign cmd_ok       = (item_r.ir_command < 8'(KEY_CHUNKS));
  assign ld_idx       = IDX_W'(item_r.chunk_index);
  assign rx_idx       = IDX_W'(item_r.ir_command);
  assign is_start_pkt = (item_r.ir_address == START_ADDR) && (item_r.ir_command == START_CMD);
  assign is_ack_pkt   = (item_r.ir_address == ACK_ADDR) && (item_r.ir_command == ACK_CMD);
  assign elapsed_inc  = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;
  assign map_set      = chunk_seen_map | (KEY_CHUNKS'(1) << rx_idx);

  // Local key read port: item index while executing, chunk number while emitting.
  assign rd_idx  = cmd.execute ? ld_idx : IDX_W'(cmd.chunk);
  assign rd_data = local_key[rd_idx];

  // Execute step: protocol decisions for one item.
  always_comb begin
    protocol_state_next = protocol_state;
    is_initiator_next   = is_initiator;
    retry_count_next    = retry_count;
    elapsed_ms_next     = elapsed_ms;
    chunk_seen_map_next = chunk_seen_map;
    key_valid_next      = key_valid;
    plan                = PLAN_NONE;
    load_we             = 1'b0;
    rx_we               = 1'b0;
    copy_en             = 1'b0;
    case (item_r.kind)
      KIND_ENTER: begin
        protocol_state_next = ST_WAITING;
        is_initiator_next   = 1'b0;
        retry_count_next    = '0;
        key_valid_next      = 1'b0;
        chunk_seen_map_next = '0;
      end
      KIND_START: begin
        if (protocol_state == ST_WAITING || protocol_state == ST_FAILED ||
            protocol_state == ST_SUCCESS) begin
          chunk_seen_map_next = '0;
          is_initiator_next   = 1'b1;
          key_valid_next      = 1'b1;
          protocol_state_next = ST_WAIT_ACK;
          elapsed_ms_next     = '0;
          retry_count_next    = 4'd1;
          plan                = PLAN_BURST;
        end
      end
      KIND_PACKET: begin
        if (is_start_pkt && !is_initiator) begin
          chunk_seen_map_next = '0;
          protocol_state_next = ST_RECEIVING;
        end else if (is_ack_pkt && is_initiator && protocol_state == ST_WAIT_ACK) begin
          protocol_state_next = ST_SUCCESS;
        end else if (!is_initiator && protocol_state == ST_RECEIVING && cmd_ok) begin
          rx_we               = 1'b1;
          chunk_seen_map_next = map_set;
          if (map_set == {KEY_CHUNKS{1'b1}}) begin
            copy_en             = 1'b1;
            key_valid_next      = 1'b1;
            protocol_state_next = ST_SUCCESS;
            plan                = PLAN_ACK;
          end
        end
      end
      KIND_TICK: begin
        if (is_initiator && protocol_state == ST_WAIT_ACK) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc >= resend_interval) begin
            if (retry_count >= max_retries) begin
              protocol_state_next = ST_FAILED;
            end else begin
              elapsed_ms_next  = '0;
              retry_count_next = retry_count + 4'd1;
              plan             = PLAN_BURST;
            end
          end
        end
      end
      KIND_LOAD: begin
        load_we = idx_ok;
      end
      default: begin
      end
    endcase
  end

  assign sts.plan     = plan;
  assign sts.out_free = !result_valid || !result_stall;

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_state <= ST_WAITING;
      is_initiator   <= 1'b0;
      retry_count    <= '0;
      elapsed_ms     <= '0;
      chunk_seen_map <= '0;
      key_valid      <= 1'b0;
    end else if (cmd.execute) begin
      protocol_state <= protocol_state_next;
      is_initiator   <= is_initiator_next;
      retry_count    <= retry_count_next;
      elapsed_ms     <= elapsed_ms_next;
      chunk_seen_map <= chunk_seen_map_next;
      key_valid      <= key_valid_next;
    end
  end

  // Word returned by a read item; zero for every other item and for a read item whose index is out of range.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      key_word <= (item_r.kind == KIND_READ && idx_ok) ? rd_data : 16'd0;
    end
  end

  // Local key store: loaded chunk by chunk, or replaced by a completed received key.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_CHUNKS; i++) local_key[i] <= '0;
    end else if (cmd.execute) begin
      for (int i = 0; i < KEY_CHUNKS; i++) begin
        if (load_we && ld_idx == IDX_W'(i)) begin
          local_key[i] <= item_r.chunk_value;
        end else if (copy_en) begin
          local_key[i] <= (rx_idx == IDX_W'(i)) ? item_r.ir_address : rx_key[i];
        end
      end
    end
  end

  // Received key store. Every entry is rewritten before the bitmap fills,
  // so it needs no clearing.
  always_ff @(posedge clk) begin
    if (cmd.execute && rx_we) begin
      for (int i = 0; i < KEY_CHUNKS; i++) begin
        if (rx_idx == IDX_W'(i)) rx_key[i] <= item_r.ir_address;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.pair_status <= protocol_state;
      result.key_ready   <= key_valid;
      result.key_word    <= key_word;
      result.last        <= cmd.last;
      case (cmd.pkt)
        PKT_START: begin
          result.send_valid   <= 1'b1;
          result.send_address <= START_ADDR;
          result.send_command <= START_CMD;
        end
        PKT_CHUNK: begin
          result.send_valid   <= 1'b1;
          result.send_address <= rd_data;
          result.send_command <= 8'(cmd.chunk);
        end
        PKT_ACK: begin
          result.send_valid   <= 1'b1;
          result.send_address <= ACK_ADDR;
          result.send_command <= ACK_CMD;
        end
        default: begin
          result.send_valid   <= 1'b0;
          result.send_address <= '0;
          result.send_command <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ir_key_pairing_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ir_key_pairing_engine_unit: IR key pairing engine, top level
// Exchanges a key of 16-bit chunks as address/command packets, as initiator
// (burst and resend) or receiver (bitmap and acknowledge).
// ----------------------------------------------------------------------------
// Usage:
// Items enter on item_valid/item_stall; a transfer happens when valid is high
// and stall is low. Each item gives one or more results on result_valid/
// result_stall, the final one flagged by last. An item that sends nothing
// gives one result; a key burst gives KEY_CHUNKS + 1 results and a completed
// reception ACK_REPEATS results.
// The item is captured and executed, and its first result is then registered
// in the output register; the following results come one per cycle while the
// receiver takes them. An item occupies the block until its last result is
// loaded; the next item is taken in the cycle after the last result is
// loaded. The step counter of the controller paces the results, one chunk
// packet read from the local key store per cycle while the receiver takes
// them. When the receiver stalls, the output register holds its result and
// the block waits. Configuration writes on cfg_valid/cfg_ready are always
// taken. Reset clears the pairing state, both configuration registers to their
// defaults and the local key to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_key_pairing_engine_unit
  import irkp_pkg::*;
#(
  parameter int KEY_CHUNKS  = KEY_CHUNKS_DEF,
  parameter int ACK_REPEATS = ACK_REPEATS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]            cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Configuration registers never hold off a write.
  assign cfg_ready = 1'b1;

  // Sequencing controller.
  irkp_ctrl #(
    .KEY_CHUNKS  (KEY_CHUNKS),
    .ACK_REPEATS (ACK_REPEATS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Pairing state, key stores and output register.
  irkp_datapath #(
    .KEY_CHUNKS  (KEY_CHUNKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire
